// File: hw/rtl/hcm_pkg.sv
// Package for the hotkey chord matcher: field widths, operation codes
// and the default sizes of the key map and the chord table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hcm_pkg;

  localparam int FUNC_W    = 2;
  localparam int CODE_W    = 16;
  localparam int COUNT_W   = 3;
  localparam int INDEX_W   = 4;
  localparam int KEY_FIELDS = 4;

  localparam logic [FUNC_W-1:0] FUNC_DOWN     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UP       = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REGISTER = 2'd2;

  localparam int DEF_NUM_TRACKED_KEYS   = 256;
  localparam int DEF_MAX_CHORDS         = 16;
  localparam int DEF_MAX_KEYS_PER_CHORD = 4;

endpackage

`default_nettype wire

// File: hw/rtl/hotkey_chord_matcher_core.sv
// Hotkey chord matcher: tracks pressed keys in a bit memory and matches
// key-up words against a chord table memory. Depends on hcm_pkg.
// Key-down, register, unused and key-up words that are disarmed or meet an
// empty chord table give their result in the cycle after acceptance. An
// armed key-up walks the chord table newest first: per chord a row read in
// S_ROW, then per key a check in S_KEY, plus a key map read in S_PCHK for a
// tracked key other than the released one. One word is in flight at a time;
// busy is high while it is. After reset a clearing pass zeroes the key map
// with busy high. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module hotkey_chord_matcher_core #(
  parameter int NUM_TRACKED_KEYS   = hcm_pkg::DEF_NUM_TRACKED_KEYS,
  parameter int MAX_CHORDS         = hcm_pkg::DEF_MAX_CHORDS,
  parameter int MAX_KEYS_PER_CHORD = hcm_pkg::DEF_MAX_KEYS_PER_CHORD
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [hcm_pkg::FUNC_W-1:0]    func,
  input  wire logic [hcm_pkg::CODE_W-1:0]    scancode,
  input  wire logic [hcm_pkg::COUNT_W-1:0]   key_count,
  input  wire logic [hcm_pkg::CODE_W-1:0]    chord_key0,
  input  wire logic [hcm_pkg::CODE_W-1:0]    chord_key1,
  input  wire logic [hcm_pkg::CODE_W-1:0]    chord_key2,
  input  wire logic [hcm_pkg::CODE_W-1:0]    chord_key3,
  output logic                               done,
  output logic                               fired,
  output logic [hcm_pkg::INDEX_W-1:0]        chord_index,
  output logic                               rejected
);
  import hcm_pkg::*;

  localparam int PM_W   = $clog2(NUM_TRACKED_KEYS);
  localparam int ADDR_W = (MAX_CHORDS > 1) ? $clog2(MAX_CHORDS) : 1;
  localparam int CNT_W  = $clog2(MAX_CHORDS + 1);
  localparam int K_W    = $clog2(MAX_KEYS_PER_CHORD + 1);
  localparam int KI_W   = (MAX_KEYS_PER_CHORD > 1) ? $clog2(MAX_KEYS_PER_CHORD) : 1;
  localparam int CMP_W  = (K_W > COUNT_W) ? K_W : COUNT_W;
  localparam int KEY_LIMIT = (MAX_KEYS_PER_CHORD < KEY_FIELDS) ?
                             MAX_KEYS_PER_CHORD : KEY_FIELDS;

  typedef struct packed {
    logic [COUNT_W-1:0]                          len;
    logic [MAX_KEYS_PER_CHORD-1:0][CODE_W-1:0]   keys;
  } row_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROW,
    S_KEY,
    S_PCHK
  } state_t;

  state_t             state;
  logic [PM_W-1:0]    clr_addr;
  logic               armed;
  logic [CNT_W-1:0]   chord_count;
  logic [ADDR_W-1:0]  cur;
  logic [K_W-1:0]     k;
  logic [CODE_W-1:0]  code_q;

  logic               pressed_mem [NUM_TRACKED_KEYS];
  logic               pm_q;
  row_t               chord_mem [MAX_CHORDS];
  row_t               row_q;

  logic               accept;
  logic               code_tracked;
  logic               table_full;
  logic               pm_we;
  logic [PM_W-1:0]    pm_waddr;
  logic               pm_wdata;
  logic               pm_re;
  logic               row_we;
  row_t               row_wdata;
  logic [CODE_W-1:0]  in_keys [KEY_FIELDS];
  logic [COUNT_W-1:0] len_sat;
  logic [CODE_W-1:0]  key_cur;
  logic               key_tracked;
  logic               key_end;
  logic [CNT_W-1:0]   cnt_dec;
  logic [ADDR_W+INDEX_W-1:0] cur_ext;
  logic [CNT_W+INDEX_W-1:0]  cnt_ext;

  assign busy         = (state != S_IDLE);
  assign accept       = start && (state == S_IDLE);
  assign code_tracked = (scancode < CODE_W'(NUM_TRACKED_KEYS));
  assign table_full   = (chord_count >= CNT_W'(MAX_CHORDS));
  assign cnt_dec      = chord_count - CNT_W'(1);
  assign cur_ext      = {{INDEX_W{1'b0}}, cur};
  assign cnt_ext      = {{INDEX_W{1'b0}}, chord_count};

  assign in_keys[0] = chord_key0;
  assign in_keys[1] = chord_key1;
  assign in_keys[2] = chord_key2;
  assign in_keys[3] = chord_key3;

  assign key_cur     = row_q.keys[k[KI_W-1:0]];
  assign key_tracked = (key_cur < CODE_W'(NUM_TRACKED_KEYS));
  assign key_end     = (CMP_W'(k) == CMP_W'(row_q.len));

  always_comb begin
    if (key_count > COUNT_W'(KEY_LIMIT)) begin
      len_sat = COUNT_W'(KEY_LIMIT);
    end else begin
      len_sat = key_count;
    end
    row_wdata.len = len_sat;
    for (int i = 0; i < MAX_KEYS_PER_CHORD; i++) begin
      if (i < KEY_FIELDS) begin
        row_wdata.keys[i] = in_keys[i];
      end else begin
        row_wdata.keys[i] = '0;
      end
    end
  end

  always_comb begin
    pm_we    = 1'b0;
    pm_waddr = clr_addr;
    pm_wdata = 1'b0;
    if (state == S_CLEAR) begin
      pm_we = 1'b1;
    end else if (accept && code_tracked && (func == FUNC_DOWN || func == FUNC_UP)) begin
      pm_we    = 1'b1;
      pm_waddr = scancode[PM_W-1:0];
      pm_wdata = (func == FUNC_DOWN);
    end
  end

  assign pm_re  = (state == S_KEY) && !key_end && (key_cur != code_q) && key_tracked;
  assign row_we = accept && (func == FUNC_REGISTER) && !table_full;

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pressed_mem[pm_waddr] <= pm_wdata;
    end
    if (pm_re) begin
      pm_q <= pressed_mem[key_cur[PM_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      chord_mem[chord_count[ADDR_W-1:0]] <= row_wdata;
    end
    if (state == S_ROW) begin
      row_q <= chord_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      armed       <= 1'b1;
      chord_count <= '0;
      done        <= 1'b0;
      fired       <= 1'b0;
      chord_index <= '0;
      rejected    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + PM_W'(1);
          if (clr_addr == PM_W'(NUM_TRACKED_KEYS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            code_q      <= scancode;
            fired       <= 1'b0;
            chord_index <= '0;
            rejected    <= 1'b0;
            case (func)
              FUNC_DOWN: begin
                armed <= 1'b1;
                done  <= 1'b1;
              end
              FUNC_UP: begin
                if (armed && chord_count != '0) begin
                  armed <= 1'b0;
                  cur   <= cnt_dec[ADDR_W-1:0];
                  state <= S_ROW;
                end else begin
                  armed <= 1'b0;
                  done  <= 1'b1;
                end
              end
              FUNC_REGISTER: begin
                done <= 1'b1;
                if (table_full) begin
                  rejected <= 1'b1;
                end else begin
                  chord_index <= cnt_ext[INDEX_W-1:0];
                  chord_count <= chord_count + CNT_W'(1);
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_ROW: begin
          k     <= '0;
          state <= S_KEY;
        end
        S_KEY: begin
          if (key_end) begin
            fired       <= 1'b1;
            chord_index <= cur_ext[INDEX_W-1:0];
            done        <= 1'b1;
            state       <= S_IDLE;
          end else if (key_cur == code_q) begin
            k <= k + K_W'(1);
          end else if (key_tracked) begin
            state <= S_PCHK;
          end else if (cur == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            cur   <= cur - ADDR_W'(1);
            state <= S_ROW;
          end
        end
        S_PCHK: begin
          if (pm_q) begin
            k     <= k + K_W'(1);
            state <= S_KEY;
          end else if (cur == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            cur   <= cur - ADDR_W'(1);
            state <= S_ROW;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result word never reports a match and a full table at once.
  assert property (@(posedge clk) disable iff (rst) done |-> !(fired && rejected))
    else $error("fired and rejected both set");

  // A rejected registration carries index zero.
  assert property (@(posedge clk) disable iff (rst) (done && rejected) |-> chord_index == '0)
    else $error("rejected word with nonzero index");

  // A key-up while disarmed answers in the next cycle without a match.
  assert property (@(posedge clk) disable iff (rst)
      (accept && func == FUNC_UP && !armed) |=> (done && !fired))
    else $error("disarmed key-up mishandled");

  // The chord count never runs past the table size.
  assert property (@(posedge clk) disable iff (rst) chord_count <= CNT_W'(MAX_CHORDS))
    else $error("chord count overflow");

endmodule

`default_nettype wire

// File: verif/hotkey_chord_matcher_core_tb.sv
// Testbench for hotkey_chord_matcher_core: a directed table, then random key
// gestures and chord registrations, each word checked against its table entry
// or an in-bench model. Depends on hcm_pkg and hotkey_chord_matcher_core.
`timescale 1ns / 1ps

module hotkey_chord_matcher_core_tb;
  import hcm_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int N_KEYS = DEF_NUM_TRACKED_KEYS;
  localparam int N_CHORDS = DEF_MAX_CHORDS;
  localparam int KEYS_PER_CHORD = DEF_MAX_KEYS_PER_CHORD;
  localparam int KEY_LIMIT = (KEYS_PER_CHORD < KEY_FIELDS) ? KEYS_PER_CHORD : KEY_FIELDS;
  localparam int WORD_TARGET = 1050;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int CODE_MAX = 65535;

  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic [CODE_W-1:0] code;
    logic [COUNT_W-1:0] count;
    logic [KEY_FIELDS-1:0][CODE_W-1:0] keys;
  } key_word_t;

  typedef struct packed {
    logic fired;
    logic [INDEX_W-1:0] index;
    logic rejected;
  } chord_result_t;

  typedef struct packed {
    key_word_t word;
    logic typed;
    chord_result_t result;
  } table_row_t;

  logic clk, rst, start, busy, done, fired, rejected;
  logic [FUNC_W-1:0] func;
  logic [CODE_W-1:0] scancode, chord_key0, chord_key1, chord_key2, chord_key3;
  logic [COUNT_W-1:0] key_count;
  logic [INDEX_W-1:0] chord_index;
  logic typed_word;
  chord_result_t typed_result;

  logic [N_KEYS-1:0] held_keys;
  logic armed;
  int chord_total;
  logic [COUNT_W-1:0] chord_len [N_CHORDS];
  logic [CODE_W-1:0] chord_code [N_CHORDS][KEYS_PER_CHORD];
  chord_result_t pending_results[$];
  int error_count = 0;
  int idle_cycles = 0;
  int words_sent = 0;
  int gap_pct = 0;

  hotkey_chord_matcher_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .scancode(scancode), .key_count(key_count), .chord_key0(chord_key0),
    .chord_key1(chord_key1), .chord_key2(chord_key2), .chord_key3(chord_key3),
    .done(done), .fired(fired), .chord_index(chord_index), .rejected(rejected)
  );

  always #4 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Applies one word to the model state and returns the result it must give.
  function automatic chord_result_t chord_match_step(key_word_t w);
    chord_result_t r;
    int len;
    logic hit;
    r = '0;
    case (w.op)
      FUNC_DOWN: begin
        if (w.code < N_KEYS) held_keys[w.code] = 1'b1;
        armed = 1'b1;
      end
      FUNC_UP: begin
        if (w.code < N_KEYS) held_keys[w.code] = 1'b0;
        if (armed) begin
          for (int c = chord_total - 1; c >= 0 && !r.fired; c--) begin
            hit = 1'b1;
            for (int k = 0; k < chord_len[c]; k++) begin
              if (chord_code[c][k] != w.code &&
                  !(chord_code[c][k] < N_KEYS && held_keys[chord_code[c][k]]))
                hit = 1'b0;
            end
            if (hit) begin
              r.fired = 1'b1;
              r.index = INDEX_W'(c);
            end
          end
          armed = 1'b0;
        end
      end
      FUNC_REGISTER: begin
        if (chord_total >= N_CHORDS) begin
          r.rejected = 1'b1;
        end else begin
          len = (w.count > COUNT_W'(KEY_LIMIT)) ? KEY_LIMIT : int'(w.count);
          chord_len[chord_total] = COUNT_W'(len);
          for (int k = 0; k < len; k++) chord_code[chord_total][k] = w.keys[k];
          r.index = INDEX_W'(chord_total);
          chord_total++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic key_word_t rand_word();
    key_word_t w;
    w.op = FUNC_UNUSED;
    w.code = CODE_W'($urandom);
    w.count = COUNT_W'($urandom);
    for (int k = 0; k < KEY_FIELDS; k++) w.keys[k] = CODE_W'($urandom);
    return w;
  endfunction

  // Mostly a small pool of codes so that chords actually match.
  function automatic logic [CODE_W-1:0] pick_key();
    case ($urandom_range(19))
      0: return CODE_W'(N_KEYS - 1);
      1: return CODE_W'(N_KEYS);
      2: return CODE_W'(CODE_MAX);
      3: return CODE_W'($urandom);
      default: return CODE_W'($urandom_range(11));
    endcase
  endfunction

  function automatic table_row_t key_row(logic [FUNC_W-1:0] op, int code,
                                         logic typed, logic f, int idx);
    table_row_t row;
    row.word = '1;
    row.word.op = op;
    row.word.code = CODE_W'(code);
    row.typed = typed;
    row.result = '0;
    row.result.fired = f;
    row.result.index = INDEX_W'(idx);
    return row;
  endfunction

  function automatic table_row_t reg_row(int count, int k0, int k1, int k2, int k3, int idx);
    table_row_t row;
    row.word.op = FUNC_REGISTER;
    row.word.code = CODE_W'(CODE_MAX);
    row.word.count = COUNT_W'(count);
    row.word.keys = {k3[CODE_W-1:0], k2[CODE_W-1:0], k1[CODE_W-1:0], k0[CODE_W-1:0]};
    row.typed = 1'b1;
    row.result = '0;
    row.result.index = INDEX_W'(idx);
    return row;
  endfunction

  task automatic send_word(key_word_t w, logic chk, chord_result_t want);
    func <= w.op;
    scancode <= w.code;
    key_count <= w.count;
    chord_key0 <= w.keys[0];
    chord_key1 <= w.keys[1];
    chord_key2 <= w.keys[2];
    chord_key3 <= w.keys[3];
    typed_word <= chk;
    typed_result <= want;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if (w.op != FUNC_UNUSED) words_sent++;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic key_event(logic [FUNC_W-1:0] op, logic [CODE_W-1:0] code);
    key_word_t w;
    w = rand_word();
    w.op = op;
    w.code = code;
    send_word(w, 1'b0, '0);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Press a chord (usually a registered one), then release it in random order.
  task automatic play_gesture();
    logic [CODE_W-1:0] keys_down [KEY_FIELDS];
    logic [CODE_W-1:0] t, extra;
    int n, c, j;
    if (chord_total > 0 && $urandom_range(9) < 7) begin
      c = $urandom_range(chord_total - 1);
      n = int'(chord_len[c]);
      for (int k = 0; k < n; k++) keys_down[k] = chord_code[c][k];
    end else begin
      n = $urandom_range(1, KEY_FIELDS);
      for (int k = 0; k < n; k++) keys_down[k] = pick_key();
    end
    for (int k = 0; k < n; k++) key_event(FUNC_DOWN, keys_down[k]);
    extra = pick_key();
    if (n == 0 || $urandom_range(3) == 0) key_event(FUNC_DOWN, extra);
    for (int k = n - 1; k > 0; k--) begin
      j = $urandom_range(k);
      t = keys_down[k];
      keys_down[k] = keys_down[j];
      keys_down[j] = t;
    end
    for (int k = 0; k < n; k++) begin
      key_event(FUNC_UP, keys_down[k]);
      if ($urandom_range(4) == 0) begin
        key_event(FUNC_DOWN, keys_down[k]);
        key_event(FUNC_UP, keys_down[k]);
      end
    end
    if (extra < N_KEYS && held_keys[extra]) key_event(FUNC_UP, extra);
  endtask

  always @(posedge clk) begin
    chord_result_t got, want;
    key_word_t w;
    if (!rst) begin
      if (done) begin
        got.fired = fired;
        got.index = chord_index;
        got.rejected = rejected;
        if (pending_results.size() == 0) begin
          flag_error("result word with no word outstanding");
        end else begin
          want = pending_results.pop_front();
          if (got.fired !== want.fired)
            flag_error($sformatf("fired %b, expected %b", got.fired, want.fired));
          if (got.index !== want.index)
            flag_error($sformatf("chord_index %0d, expected %0d", got.index, want.index));
          if (got.rejected !== want.rejected)
            flag_error($sformatf("rejected %b, expected %b", got.rejected, want.rejected));
        end
      end
      if (start && !busy) begin
        w.op = func;
        w.code = scancode;
        w.count = key_count;
        w.keys = {chord_key3, chord_key2, chord_key1, chord_key0};
        want = chord_match_step(w);
        pending_results.push_back(typed_word ? typed_result : want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("hotkey_chord_matcher_core_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    table_row_t rows[$];
    key_word_t w;
    int pick;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_DOWN;
    scancode = '0;
    key_count = '0;
    chord_key0 = '0;
    chord_key1 = '0;
    chord_key2 = '0;
    chord_key3 = '0;
    typed_word = 1'b0;
    typed_result = '0;
    held_keys = '0;
    armed = 1'b1;
    chord_total = 0;

    rows.push_back(key_row(FUNC_UP, 5, 1'b1, 1'b0, 0));
    rows.push_back(key_row(FUNC_UNUSED, CODE_MAX, 1'b1, 1'b0, 0));
    rows.push_back(reg_row(0, 0, 0, 0, 0, 0));
    rows.push_back(key_row(FUNC_DOWN, 0, 1'b1, 1'b0, 0));
    rows.push_back(key_row(FUNC_UP, 0, 1'b1, 1'b1, 0));
    rows.push_back(key_row(FUNC_UP, 0, 1'b1, 1'b0, 0));
    rows.push_back(reg_row(2, 1, 2, CODE_MAX, CODE_MAX, 1));
    rows.push_back(reg_row(7, 3, 4, N_KEYS - 1, CODE_MAX, 2));
    rows.push_back(reg_row(3, N_KEYS, 1, 2, 0, 3));
    rows.push_back(key_row(FUNC_DOWN, 1, 1'b1, 1'b0, 0));
    rows.push_back(key_row(FUNC_DOWN, 2, 1'b1, 1'b0, 0));
    rows.push_back(key_row(FUNC_UP, 1, 1'b0, 1'b0, 0));
    rows.push_back(key_row(FUNC_UP, 2, 1'b0, 1'b0, 0));
    rows.push_back(key_row(FUNC_DOWN, 2, 1'b1, 1'b0, 0));
    rows.push_back(key_row(FUNC_DOWN, 1, 1'b1, 1'b0, 0));
    rows.push_back(key_row(FUNC_UP, N_KEYS, 1'b0, 1'b0, 0));
    rows.push_back(key_row(FUNC_UP, 1, 1'b0, 1'b0, 0));
    rows.push_back(key_row(FUNC_UP, 2, 1'b0, 1'b0, 0));
    rows.push_back(key_row(FUNC_DOWN, 3, 1'b1, 1'b0, 0));
    rows.push_back(key_row(FUNC_DOWN, 4, 1'b1, 1'b0, 0));
    rows.push_back(key_row(FUNC_DOWN, N_KEYS - 1, 1'b1, 1'b0, 0));
    rows.push_back(key_row(FUNC_UP, CODE_MAX, 1'b0, 1'b0, 0));
    rows.push_back(key_row(FUNC_UP, 3, 1'b0, 1'b0, 0));
    rows.push_back(key_row(FUNC_UP, 4, 1'b0, 1'b0, 0));
    rows.push_back(key_row(FUNC_UP, N_KEYS - 1, 1'b0, 1'b0, 0));
    rows.push_back(key_row(FUNC_DOWN, CODE_MAX, 1'b1, 1'b0, 0));
    rows.push_back(key_row(FUNC_UP, 7, 1'b0, 1'b0, 0));

    gap_pct = 28;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].result);

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 28 : (phase == 1) ? 46 : 0;
      while (words_sent < (phase + 1) * WORD_TARGET / 3) begin
        pick = $urandom_range(99);
        if (pick < 12 && (chord_total < N_CHORDS || pick < 4)) begin
          w = rand_word();
          w.op = FUNC_REGISTER;
          for (int k = 0; k < KEY_FIELDS; k++) w.keys[k] = pick_key();
          send_word(w, 1'b0, '0);
        end else if (pick < 65) begin
          play_gesture();
        end else if (pick < 90) begin
          key_event(($urandom_range(9) < 4) ? FUNC_DOWN : FUNC_UP, pick_key());
        end else if (pick < 95) begin
          for (int k = 0; k < N_KEYS; k++) begin
            if (held_keys[k]) key_event(FUNC_UP, CODE_W'(k));
          end
        end else begin
          send_word(rand_word(), 1'b0, '0);
        end
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("hotkey_chord_matcher_core_tb: PASS");
    end else begin
      $display("hotkey_chord_matcher_core_tb: FAIL");
    end
    $finish;
  end

endmodule
